>>> hw/rtl/dram_region_fault_detector_top_macros.svh
// Assertion macros shared by the DRAM region fault detector RTL.
// No dependencies; included by the files that carry assertions.
`ifndef DRAM_REGION_FAULT_DETECTOR_TOP_MACROS_SVH
`define DRAM_REGION_FAULT_DETECTOR_TOP_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define DRFD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define DRFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/drfd_pkg.sv
// Types and constants of the DRAM region fault detector.
// No dependencies; used by the controller, datapath and top level.
package drfd_pkg;

  localparam int LOC_W     = 30;
  localparam int TIME_W    = 41;
  localparam int STAMP_W   = 40;
  localparam int ROW_W     = 18;
  localparam int CHAN_W    = 4;
  localparam int RANK_W    = 3;
  localparam int BANK_W    = 5;
  localparam int CNT_W     = 7;
  localparam int SPAN_W    = 8;
  localparam int TWIN_W    = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_SPAN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ERRORS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW = 2'd2;

  localparam logic [SPAN_W-1:0] ROW_SPAN_RST    = 8'd8;
  localparam logic [CNT_W-1:0]  MIN_ERRORS_RST  = 7'd3;
  localparam logic [TWIN_W-1:0] TIME_WINDOW_RST = 20'd3600;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_I,
    S_CAP_I,
    S_SCAN_J,
    S_DIFF,
    S_DECIDE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic ld;
    logic cap_i;
    logic chk_j;
    logic calc_diff;
    logic take;
    logic emit;
    logic emit_last;
    logic next_i;
    logic clear_run;
  } ctl_cmd_t;

  typedef struct packed {
    logic i_end;
    logic j_end;
    logic loc_match;
    logic det;
    logic pend_valid;
    logic out_free;
  } ctl_sts_t;

endpackage

>>> hw/rtl/dram_region_fault_detector_top.sv
// Top level of the DRAM region fault detector.
// Depends on drfd_pkg, drfd_ctrl, drfd_dp and drfd_ram.
//
// Usage: error records enter on the in_ channel, one item per cycle while the
// block is loading. The record with in_final_record set closes the run and
// starts the window scan; in_stall stays high until the run's results are out.
// Up to DEPTH records are stored; later ones are dropped and the run's results
// carry out_overflowed.
// Results leave on the out_ channel from one output register. Every detected
// window gives one item in start order; a run without detections gives one
// empty item. out_last_result marks the final item of the run.
// Scan: both stores are read through one read port. For each start record i
// the scan reads the later records up to and including the first of another
// channel, rank or bank, or up to the end of the store. A detection waits in
// a one-entry holding register until the next one is found or the run ends,
// so the scan stalls when out_stall holds the output register and a new
// detection arrives. Configuration writes on the cfg_ channel are always ready
// and should be made only while idle. Reset (rst_n low, synchronous) empties
// the store and restores the register defaults; no clearing pass is needed.
module dram_region_fault_detector_top #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [drfd_pkg::CHAN_W-1:0]    in_chan,
  input  logic [drfd_pkg::RANK_W-1:0]    in_rank_id,
  input  logic [drfd_pkg::BANK_W-1:0]    in_bank_id,
  input  logic [drfd_pkg::ROW_W-1:0]     in_row_addr,
  input  logic [drfd_pkg::STAMP_W-1:0]   in_stamp,
  input  logic                           in_stamp_ok,
  input  logic                           in_final_record,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_detected,
  output logic [drfd_pkg::CNT_W-1:0]     out_win_count,
  output logic [drfd_pkg::CHAN_W-1:0]    out_chan,
  output logic [drfd_pkg::RANK_W-1:0]    out_rank,
  output logic [drfd_pkg::BANK_W-1:0]    out_bank,
  output logic [drfd_pkg::ROW_W-1:0]     out_first_row,
  output logic [drfd_pkg::ROW_W-1:0]     out_last_row,
  output logic [drfd_pkg::ROW_W-1:0]     out_mid_row,
  output logic                           out_overflowed,
  output logic                           out_last_result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [drfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [drfd_pkg::CFG_DAT_W-1:0] cfg_data
);
  import drfd_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  drfd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_final_record (in_final_record),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .sts             (sts)
  );

  drfd_dp #(.DEPTH(DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_chan         (in_chan),
    .in_rank_id      (in_rank_id),
    .in_bank_id      (in_bank_id),
    .in_row_addr     (in_row_addr),
    .in_stamp        (in_stamp),
    .in_stamp_ok     (in_stamp_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_detected    (out_detected),
    .out_win_count   (out_win_count),
    .out_chan        (out_chan),
    .out_rank        (out_rank),
    .out_bank        (out_bank),
    .out_first_row   (out_first_row),
    .out_last_row    (out_last_row),
    .out_mid_row     (out_mid_row),
    .out_overflowed  (out_overflowed),
    .out_last_result (out_last_result)
  );

endmodule

>>> hw/rtl/drfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the record stores of the detector.
module drfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/drfd_ctrl.sv
// Sequencer of the DRAM region fault detector: load, window scan and emit.
// Depends on drfd_pkg for the state, command and status types.
module drfd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_final_record,
  output logic               in_stall,
  output drfd_pkg::ctl_cmd_t cmd,
  input  drfd_pkg::ctl_sts_t sts
);
  import drfd_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   dec_wait;

  assign dec_wait = sts.det && sts.pend_valid && !sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid && in_final_record) state_nxt = S_RD_I;
      end
      S_RD_I:   state_nxt = S_CAP_I;
      S_CAP_I:  state_nxt = sts.i_end ? S_DIFF : S_SCAN_J;
      S_SCAN_J: begin
        if (!sts.loc_match || sts.j_end) state_nxt = S_DIFF;
      end
      S_DIFF:   state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!dec_wait) state_nxt = sts.i_end ? S_FINISH : S_RD_I;
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_LOAD;
      end
      default:  state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        cmd.ld   = in_valid;
      end
      S_RD_I:   cmd = '0;
      S_CAP_I:  cmd.cap_i = 1'b1;
      S_SCAN_J: cmd.chk_j = 1'b1;
      S_DIFF:   cmd.calc_diff = 1'b1;
      S_DECIDE: begin
        if (!dec_wait) begin
          cmd.take   = sts.det;
          cmd.emit   = sts.det && sts.pend_valid;
          cmd.next_i = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.clear_run = 1'b1;
        end
      end
      default:  cmd = '0;
    endcase
  end

endmodule

>>> hw/rtl/drfd_dp.sv
// Datapath of the DRAM region fault detector: stores, window registers,
// configuration registers and result register. Depends on drfd_pkg and drfd_ram.
`include "dram_region_fault_detector_top_macros.svh"

module drfd_dp #(
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  drfd_pkg::ctl_cmd_t                     cmd,
  output drfd_pkg::ctl_sts_t                     sts,
  input  logic                                   cfg_valid,
  input  logic [drfd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [drfd_pkg::CFG_DAT_W-1:0]         cfg_data,
  input  logic [drfd_pkg::CHAN_W-1:0]            in_chan,
  input  logic [drfd_pkg::RANK_W-1:0]            in_rank_id,
  input  logic [drfd_pkg::BANK_W-1:0]            in_bank_id,
  input  logic [drfd_pkg::ROW_W-1:0]             in_row_addr,
  input  logic [drfd_pkg::STAMP_W-1:0]           in_stamp,
  input  logic                                   in_stamp_ok,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_detected,
  output logic [drfd_pkg::CNT_W-1:0]             out_win_count,
  output logic [drfd_pkg::CHAN_W-1:0]            out_chan,
  output logic [drfd_pkg::RANK_W-1:0]            out_rank,
  output logic [drfd_pkg::BANK_W-1:0]            out_bank,
  output logic [drfd_pkg::ROW_W-1:0]             out_first_row,
  output logic [drfd_pkg::ROW_W-1:0]             out_last_row,
  output logic [drfd_pkg::ROW_W-1:0]             out_mid_row,
  output logic                                   out_overflowed,
  output logic                                   out_last_result
);
  import drfd_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int ROW_LO = ROW_W;

  logic [CW-1:0]     rec_cnt_r, rec_cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic [CW-1:0]     i_inc, j_inc;
  logic [SPAN_W-1:0] row_span_r;
  logic [CNT_W-1:0]  min_err_r;
  logic [TWIN_W-1:0] time_win_r;

  logic [LOC_W-1:0]   win_loc_r;
  logic [TIME_W-1:0]  win_t_r;
  logic [ROW_W-1:0]   top_r;
  logic [CNT_W-1:0]   wcnt_r;
  logic [TIME_W-1:0]  last_t_r;
  logic [STAMP_W-1:0] diff_r;

  logic               pend_valid_r, pend_valid_nxt;
  logic [LOC_W-1:0]   pend_loc_r;
  logic [ROW_W-1:0]   pend_top_r;
  logic [CNT_W-1:0]   pend_cnt_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  logic               st_we;
  logic [IW-1:0]      raddr;
  logic [LOC_W-1:0]   loc_q;
  logic [TIME_W-1:0]  time_q;
  logic [LOC_W-1:0]   loc_wr;
  logic [TIME_W-1:0]  time_wr;

  logic [ROW_W-1:0]   row_q;
  logic [ROW_W-1:0]   cand;
  logic [ROW_W-1:0]   row_gap;
  logic               joins;
  logic [STAMP_W:0]   sub_ab;
  logic [STAMP_W-1:0] sub_ba;
  logic [ROW_W:0]     row_sum;

  assign i_inc   = i_r + 1'b1;
  assign j_inc   = j_r + 1'b1;
  assign loc_wr  = {in_chan, in_rank_id, in_bank_id, in_row_addr};
  assign time_wr = {in_stamp_ok, in_stamp};
  assign st_we   = cmd.ld && (rec_cnt_r != CW'(DEPTH));

  always_comb begin
    priority if (cmd.cap_i) raddr = i_inc[IW-1:0];
    else if (cmd.chk_j)     raddr = j_inc[IW-1:0];
    else                    raddr = i_r[IW-1:0];
  end

  drfd_ram #(.WIDTH(LOC_W), .DEPTH(DEPTH)) u_loc_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (rec_cnt_r[IW-1:0]),
    .wdata (loc_wr),
    .raddr (raddr),
    .rdata (loc_q)
  );

  drfd_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (rec_cnt_r[IW-1:0]),
    .wdata (time_wr),
    .raddr (raddr),
    .rdata (time_q)
  );

  assign row_q   = loc_q[ROW_W-1:0];
  assign cand    = (row_q > top_r) ? row_q : top_r;
  assign row_gap = cand - win_loc_r[ROW_W-1:0];
  assign joins   = row_gap <= {{(ROW_W-SPAN_W){1'b0}}, row_span_r};
  assign sub_ab = {1'b0, win_t_r[STAMP_W-1:0]} - {1'b0, last_t_r[STAMP_W-1:0]};
  assign sub_ba = last_t_r[STAMP_W-1:0] - win_t_r[STAMP_W-1:0];
  assign row_sum = {1'b0, pend_loc_r[ROW_W-1:0]} + {1'b0, pend_top_r};

  assign out_free = !out_valid_r || !out_stall;

  assign sts.i_end      = (i_inc == rec_cnt_r);
  assign sts.j_end      = (j_inc == rec_cnt_r);
  assign sts.loc_match  = (loc_q[LOC_W-1:ROW_LO] == win_loc_r[LOC_W-1:ROW_LO]);
  assign sts.det        = (wcnt_r >= min_err_r) && (top_r > win_loc_r[ROW_W-1:0]) &&
                          win_t_r[TIME_W-1] && last_t_r[TIME_W-1] &&
                          (diff_r <= {{(STAMP_W-TWIN_W){1'b0}}, time_win_r});
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

  always_comb begin
    rec_cnt_nxt    = rec_cnt_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = out_valid_r;
    if (cmd.ld) begin
      if (st_we) rec_cnt_nxt = rec_cnt_r + 1'b1;
      else       ovf_nxt = 1'b1;
    end
    if (cmd.cap_i)  j_nxt = i_inc;
    if (cmd.chk_j)  j_nxt = j_inc;
    if (cmd.next_i) i_nxt = i_inc;
    if (cmd.take)   pend_valid_nxt = 1'b1;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.emit)   out_valid_nxt = 1'b1;
    if (cmd.clear_run) begin
      rec_cnt_nxt    = '0;
      ovf_nxt        = 1'b0;
      i_nxt          = '0;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_cnt_r    <= '0;
      ovf_r        <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      row_span_r   <= ROW_SPAN_RST;
      min_err_r    <= MIN_ERRORS_RST;
      time_win_r   <= TIME_WINDOW_RST;
    end else begin
      rec_cnt_r    <= rec_cnt_nxt;
      ovf_r        <= ovf_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ROW_SPAN:    row_span_r <= cfg_data[SPAN_W-1:0];
          CFG_MIN_ERRORS:  min_err_r  <= cfg_data[CNT_W-1:0];
          CFG_TIME_WINDOW: time_win_r <= cfg_data[TWIN_W-1:0];
          default:         row_span_r <= row_span_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_i) begin
      win_loc_r <= loc_q;
      win_t_r   <= time_q;
      top_r     <= row_q;
      wcnt_r    <= CNT_W'(1);
      last_t_r  <= time_q;
    end else if (cmd.chk_j && sts.loc_match && joins) begin
      wcnt_r   <= wcnt_r + 1'b1;
      top_r    <= cand;
      last_t_r <= time_q;
    end
    if (cmd.calc_diff) begin
      diff_r <= sub_ab[STAMP_W] ? sub_ba : sub_ab[STAMP_W-1:0];
    end
    if (cmd.take) begin
      pend_loc_r <= win_loc_r;
      pend_top_r <= top_r;
      pend_cnt_r <= wcnt_r;
    end
    if (cmd.emit) begin
      out_overflowed  <= ovf_r;
      out_last_result <= cmd.emit_last;
      if (cmd.emit_last && !pend_valid_r) begin
        out_detected    <= 1'b0;
        out_win_count   <= '0;
        out_chan        <= '0;
        out_rank        <= '0;
        out_bank        <= '0;
        out_first_row   <= '0;
        out_last_row    <= '0;
        out_mid_row     <= '0;
      end else begin
        out_detected    <= 1'b1;
        out_win_count   <= pend_cnt_r;
        out_chan        <= pend_loc_r[LOC_W-1 -: CHAN_W];
        out_rank        <= pend_loc_r[LOC_W-CHAN_W-1 -: RANK_W];
        out_bank        <= pend_loc_r[ROW_W+BANK_W-1 -: BANK_W];
        out_first_row   <= pend_loc_r[ROW_W-1:0];
        out_last_row    <= pend_top_r;
        out_mid_row     <= row_sum[ROW_W:1];
      end
    end
  end

  assign out_valid = out_valid_r;

  `DRFD_ASSERT(a_cnt_bound, clk, rst_n, rec_cnt_r <= CW'(DEPTH), "count above depth")
  `DRFD_ASSERT_IMP(a_ovf_full, clk, rst_n, ovf_r, rec_cnt_r == CW'(DEPTH), "early overflow")
  `DRFD_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, out_free, "emit over held item")
  `DRFD_ASSERT_IMP(a_pend_rows, clk, rst_n, pend_valid_r, pend_top_r > pend_loc_r[ROW_W-1:0], "flat")

endmodule
